>>> sv/hkv_pkg.sv
// ----------------------------------------------------------------------------
// hkv_pkg
// Shared types and codes for the hashed key-value table: request actions,
// result status codes, the decoded operation and the queued request item.
// ----------------------------------------------------------------------------
package hkv_pkg;

    localparam int KEY_BITS    = 64;
    localparam int DATA_BITS   = 32;
    localparam int COUNT_BITS  = 7;
    localparam int STATUS_BITS = 3;
    localparam int ACTION_BITS = 2;

    // Request action codes as seen on the input channel
    localparam logic [ACTION_BITS-1:0] ACT_PUT    = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_REMOVED  = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FOUND    = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd5;

    // Entry limit after reset
    localparam logic [COUNT_BITS-1:0] LIMIT_RESET = 7'd12;

    // Decoded operation; unknown actions become a no-op
    typedef enum logic [1:0] {
        OP_PUT,
        OP_REMOVE,
        OP_LOOKUP,
        OP_NONE
    } op_t;

    // Classified request passed from the front end to the back end
    typedef struct packed {
        op_t                  op;
        logic [KEY_BITS-1:0]  key;
        logic [DATA_BITS-1:0] value;
    } req_t;

endpackage

>>> sv/hkv_front.sv
// ----------------------------------------------------------------------------
// hkv_front
// Accepts request items, decodes the action into an operation and holds the
// classified items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module hkv_front
    import hkv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [ACTION_BITS-1:0] action,
    input  logic [KEY_BITS-1:0]    key,
    input  logic [DATA_BITS-1:0]   value,
    output logic                   q_valid,
    input  logic                   q_ready,
    output req_t                   q_req
);

    localparam int DEPTH = 2;

    req_t       fifo_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;
    req_t       in_req;

    // Decode the action
    always_comb
    begin
        in_req.key   = key;
        in_req.value = value;
        case (action)
            ACT_PUT:    in_req.op = OP_PUT;
            ACT_REMOVE: in_req.op = OP_REMOVE;
            ACT_LOOKUP: in_req.op = OP_LOOKUP;
            default:    in_req.op = OP_NONE;
        endcase
    end

    assign in_ready = (fill_reg != 2'(DEPTH));
    assign q_valid  = (fill_reg != 2'd0);
    assign q_req    = fifo_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the classified item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

>>> sv/hkv_back.sv
// ----------------------------------------------------------------------------
// hkv_back
// Carries out queued requests: reads the bucket row from the row memory,
// matches the key against every way, then writes the row back and registers
// the result. A row written as its bucket is read again is forwarded.
// ----------------------------------------------------------------------------
module hkv_back
    import hkv_pkg::*;
#(
    parameter int BUCKETS    = 16,
    parameter int WAYS       = 4,
    parameter int VALUE_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  req_t                   q_req,
    input  logic [COUNT_BITS-1:0]  entry_limit,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STATUS_BITS-1:0] status,
    output logic [DATA_BITS-1:0]   found_value,
    output logic [COUNT_BITS-1:0]  entry_count
);

    localparam int BUCKET_BITS = $clog2(BUCKETS);
    localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef logic [WAYS-1:0][KEY_BITS-1:0]   key_row_t;
    typedef logic [WAYS-1:0][VALUE_BITS-1:0] val_row_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // Row memories, one row per bucket
    key_row_t key_mem [BUCKETS];
    val_row_t val_mem [BUCKETS];

    logic [WAYS-1:0]        way_valid_reg [BUCKETS];
    key_row_t               rd_key_reg;
    val_row_t               rd_val_reg;
    key_row_t               wr_key_reg;
    val_row_t               wr_val_reg;
    logic                   fwd_reg;
    req_t                   req_reg;
    state_t                 state_reg;
    state_t                 state_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [STATUS_BITS-1:0] status_reg;
    logic [DATA_BITS-1:0]   found_value_reg;
    logic [COUNT_BITS-1:0]  entry_count_reg;

    logic [BUCKET_BITS-1:0] q_bucket;
    logic [BUCKET_BITS-1:0] bucket;
    key_row_t               cur_key;
    val_row_t               cur_val;
    logic [WAYS-1:0]        cur_valid;
    key_row_t               new_key;
    val_row_t               new_val;
    logic [WAYS-1:0]        new_valid;
    logic                   hit_any;
    logic [WAY_BITS-1:0]    hit_way;
    logic                   free_any;
    logic [WAY_BITS-1:0]    free_way;
    logic [STATUS_BITS-1:0] st;
    logic [DATA_BITS-1:0]   fval;
    logic                   exec_done;
    logic                   pop;

    assign q_bucket  = q_req.key[BUCKET_BITS-1:0];
    assign bucket    = req_reg.key[BUCKET_BITS-1:0];
    assign cur_key   = fwd_reg ? wr_key_reg : rd_key_reg;
    assign cur_val   = fwd_reg ? wr_val_reg : rd_val_reg;
    assign cur_valid = way_valid_reg[bucket];

    // Finish the current item once the output register can take its result
    assign exec_done = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign q_ready   = (state_reg == S_IDLE) || exec_done;
    assign pop       = q_valid && q_ready;

    // Match the key and find the lowest free way
    always_comb
    begin
        hit_any  = 1'b0;
        hit_way  = '0;
        free_any = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (cur_valid[w] && (cur_key[w] == req_reg.key))
            begin
                hit_any = 1'b1;
                hit_way = WAY_BITS'(w);
            end
            if (!cur_valid[w])
            begin
                free_any = 1'b1;
                free_way = WAY_BITS'(w);
            end
        end
    end

    // Work out the new row, count and result
    always_comb
    begin
        new_key    = cur_key;
        new_val    = cur_val;
        new_valid  = cur_valid;
        count_next = count_reg;
        st         = ST_NOTFOUND;
        fval       = '0;
        case (req_reg.op)
            OP_PUT:
            begin
                if (hit_any)
                begin
                    new_val[hit_way] = VALUE_BITS'(req_reg.value);
                    st               = ST_UPDATED;
                end
                else if ((count_reg < entry_limit) && free_any)
                begin
                    new_key[free_way]   = req_reg.key;
                    new_val[free_way]   = VALUE_BITS'(req_reg.value);
                    new_valid[free_way] = 1'b1;
                    count_next          = count_reg + 7'd1;
                    st                  = ST_INSERTED;
                end
                else
                begin
                    st = ST_FULL;
                end
            end
            OP_REMOVE:
            begin
                if (hit_any)
                begin
                    new_valid[hit_way] = 1'b0;
                    count_next         = count_reg - 7'd1;
                    st                 = ST_REMOVED;
                end
            end
            OP_LOOKUP:
            begin
                if (hit_any)
                begin
                    fval = DATA_BITS'(cur_val[hit_way]);
                    st   = ST_FOUND;
                end
            end
            default:
            begin
                st = ST_NOTFOUND;
            end
        endcase
    end

    // Sequence the read and write-back steps
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_done && !pop)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (exec_done)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Hold state, count, valid bits and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
            for (int b = 0; b < BUCKETS; b++)
            begin
                way_valid_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                fwd_reg <= exec_done && (q_bucket == bucket);
            end
            if (exec_done)
            begin
                count_reg             <= count_next;
                way_valid_reg[bucket] <= new_valid;
            end
        end
    end

    // Row memory: write back the row of a finished put, read the next one
    always_ff @(posedge clk)
    begin
        if (exec_done && (req_reg.op == OP_PUT))
        begin
            key_mem[bucket] <= new_key;
            val_mem[bucket] <= new_val;
        end
        if (pop)
        begin
            rd_key_reg <= key_mem[q_bucket];
            rd_val_reg <= val_mem[q_bucket];
        end
    end

    // Capture the request, the written row and the result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            req_reg <= q_req;
        end
        if (exec_done)
        begin
            wr_key_reg      <= new_key;
            wr_val_reg      <= new_val;
            status_reg      <= st;
            found_value_reg <= fval;
            entry_count_reg <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_value = found_value_reg;
    assign entry_count = entry_count_reg;

endmodule

>>> sv/hash_key_value_table.sv
// An accepted item's request and bucket row are registered first, then its result.
// Throughput: one item per cycle; the read of the next bucket row overlaps the
// write-back of the current row, which is forwarded when the bucket repeats.
// A stalled result holds the back end; a two-entry queue keeps input open.
// Reset (rst_n, asynchronous, active low) empties the table at once through
// per-way valid bits, clears the entry count and sets the entry limit to 12.
// ----------------------------------------------------------------------------
// hash_key_value_table
// Hashed key-to-value table with BUCKETS buckets of WAYS ways each; supports
// put, remove and lookup on 64-bit keys and reports the entry count.
// ----------------------------------------------------------------------------
module hash_key_value_table
    import hkv_pkg::*;
#(
    parameter int BUCKETS    = 16,
    parameter int WAYS       = 4,
    parameter int VALUE_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [COUNT_BITS-1:0]  cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [ACTION_BITS-1:0] action,
    input  logic [KEY_BITS-1:0]    key,
    input  logic [DATA_BITS-1:0]   value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STATUS_BITS-1:0] status,
    output logic [DATA_BITS-1:0]   found_value,
    output logic [COUNT_BITS-1:0]  entry_count
);

    logic [COUNT_BITS-1:0] limit_reg;
    logic                  q_valid;
    logic                  q_ready;
    req_t                  q_req;

    // Hold the entry limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    hkv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .key      (key),
        .value    (value),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    hkv_back #(
        .BUCKETS    (BUCKETS),
        .WAYS       (WAYS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_req       (q_req),
        .entry_limit (limit_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found_value (found_value),
        .entry_count (entry_count)
    );

endmodule

>>> sv/hkv_checker.sv
// ----------------------------------------------------------------------------
// hkv_checker
// Port-level checks for the hashed key-value table, bound to the top level.
// ----------------------------------------------------------------------------
module hkv_checker
    import hkv_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [STATUS_BITS-1:0] status,
    input logic [DATA_BITS-1:0]   found_value,
    input logic [COUNT_BITS-1:0]  entry_count
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(found_value) && $stable(entry_count))
        else $error("result changed while stalled");

    // Only a found lookup carries a value
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_FOUND) |-> (found_value == '0))
        else $error("value reported without a hit");

    // Status stays within the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_FULL))
        else $error("undefined status code");

    // An insert, update or found lookup leaves at least one entry
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_INSERTED || status == ST_UPDATED
            || status == ST_FOUND) |-> (entry_count != '0))
        else $error("entry count zero with a stored key");

endmodule

bind hash_key_value_table hkv_checker u_hkv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found_value (found_value),
    .entry_count (entry_count)
);

>>> dv/tb_hash_key_value_table.sv
// ----------------------------------------------------------------------------
// tb_hash_key_value_table
// Self-checking bench for the hashed key-value table. A scoreboard keeps its
// own copy of the table and entry limit, predicts status, found value and
// entry count for every accepted request, and checks results in order.
// Stimulus is a directed opening followed by random put/remove/lookup/spare
// traffic over a recycled key pool, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_hash_key_value_table;
    import hkv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 20;
    localparam int BUCKETS         = 16;
    localparam int WAYS            = 4;
    localparam int SLOT_COUNT      = BUCKETS * WAYS;
    localparam int KEY_POOL        = 80;
    localparam int PHASE_ITEMS     = 172;
    localparam int PHASES          = 7;
    localparam int HOLD_CYCLES     = 120;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 10;
    localparam int MAX_REPORTS     = 10;
    localparam int WATCHDOG_CYCLES = 400000;

    // No named code exists for the spare action encoding
    localparam logic [ACTION_BITS-1:0] ACT_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [DATA_BITS-1:0]   found_value;
        logic [COUNT_BITS-1:0]  entry_count;
    } kv_result_t;

    // ------------------------------------------------------------------------
    // Table predictor and in-order store of expected results
    // ------------------------------------------------------------------------
    class kv_scoreboard;
        bit                    way_used [SLOT_COUNT];
        logic [KEY_BITS-1:0]   key_mem  [SLOT_COUNT];
        logic [DATA_BITS-1:0]  value_mem[SLOT_COUNT];
        logic [COUNT_BITS-1:0] count;
        logic [COUNT_BITS-1:0] limit;
        kv_result_t            expected_q[$];
        int                    errors;

        function new();
            foreach (way_used[i])
                way_used[i] = 1'b0;
            count  = '0;
            limit  = LIMIT_RESET;
            errors = 0;
        endfunction

        function void set_limit(logic [COUNT_BITS-1:0] v);
            limit = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Apply one accepted request to the table and queue its result
        function void note_request(logic [ACTION_BITS-1:0] act,
                                   logic [KEY_BITS-1:0] k,
                                   logic [DATA_BITS-1:0] v);
            op_t        op;
            int         base;
            int         hit;
            int         free_slot;
            kv_result_t r;

            case (act)
                ACT_PUT:    op = OP_PUT;
                ACT_REMOVE: op = OP_REMOVE;
                ACT_LOOKUP: op = OP_LOOKUP;
                default:    op = OP_NONE;
            endcase

            base      = int'(k % BUCKETS) * WAYS;
            hit       = -1;
            free_slot = -1;
            for (int w = 0; w < WAYS; w++)
            begin
                if (hit < 0 && way_used[base + w] && key_mem[base + w] == k)
                    hit = base + w;
                if (free_slot < 0 && !way_used[base + w])
                    free_slot = base + w;
            end

            r.status      = ST_NOTFOUND;
            r.found_value = '0;
            case (op)
                OP_PUT:
                begin
                    if (hit >= 0)
                    begin
                        value_mem[hit] = v;
                        r.status       = ST_UPDATED;
                    end
                    else if (count < limit && free_slot >= 0)
                    begin
                        way_used[free_slot]  = 1'b1;
                        key_mem[free_slot]   = k;
                        value_mem[free_slot] = v;
                        count                = count + 7'd1;
                        r.status             = ST_INSERTED;
                    end
                    else
                        r.status = ST_FULL;
                end
                OP_REMOVE:
                begin
                    if (hit >= 0)
                    begin
                        way_used[hit] = 1'b0;
                        count         = count - 7'd1;
                        r.status      = ST_REMOVED;
                    end
                end
                OP_LOOKUP:
                begin
                    if (hit >= 0)
                    begin
                        r.status      = ST_FOUND;
                        r.found_value = value_mem[hit];
                    end
                end
                default: ;
            endcase
            r.entry_count = count;
            expected_q = {expected_q, r};
        endfunction

        // Compare one accepted result against the oldest expectation
        function void check_result(logic [STATUS_BITS-1:0] st,
                                   logic [DATA_BITS-1:0] fv,
                                   logic [COUNT_BITS-1:0] cnt);
            kv_result_t exp_r;

            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with none expected: status %0d value %h count %0d",
                             $realtime, st, fv, cnt);
                return;
            end
            exp_r = expected_q.pop_front();
            if (st !== exp_r.status || fv !== exp_r.found_value ||
                cnt !== exp_r.entry_count)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: mismatch (exp/act): status %0d/%0d value %h/%h count %0d/%0d",
                             $realtime, exp_r.status, st, exp_r.found_value, fv,
                             exp_r.entry_count, cnt);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [COUNT_BITS-1:0]  cfg_wdata;
    logic                   in_valid;
    logic                   in_ready;
    logic [ACTION_BITS-1:0] action;
    logic [KEY_BITS-1:0]    key;
    logic [DATA_BITS-1:0]   value;
    logic                   out_valid;
    logic                   out_ready;
    logic [STATUS_BITS-1:0] status;
    logic [DATA_BITS-1:0]   found_value;
    logic [COUNT_BITS-1:0]  entry_count;

    kv_scoreboard        sb;
    logic [KEY_BITS-1:0] key_pool[KEY_POOL];
    bit                  gaps_on;
    int                  burst_left;
    bit                  hold_off_req;

    hash_key_value_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found_value (found_value),
        .entry_count (entry_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Note accepted requests and check accepted results on the same edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && in_valid && in_ready)
            sb.note_request(action, key, value);
        if (rst_n === 1'b1 && out_valid && out_ready)
            sb.check_result(status, found_value, entry_count);
    end

    // Offer one item and hold it until taken, then idle between bursts
    task automatic send_item(input logic [ACTION_BITS-1:0] act,
                             input logic [KEY_BITS-1:0] k,
                             input logic [DATA_BITS-1:0] v);
        int gap;

        in_valid <= 1'b1;
        action   <= act;
        key      <= k;
        value    <= v;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(1, 8);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the entry limit while the table is idle
    task automatic set_entry_limit(input logic [COUNT_BITS-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_limit(v);
    endtask

    // Mostly recycled keys so that hits, updates and full buckets are common
    task automatic random_request();
        int                     r;
        int                     pick;
        logic [ACTION_BITS-1:0] act;
        logic [KEY_BITS-1:0]    k;
        logic [DATA_BITS-1:0]   v;

        r = $urandom_range(0, 99);
        if (r < 45)
            act = ACT_PUT;
        else if (r < 65)
            act = ACT_REMOVE;
        else if (r < 95)
            act = ACT_LOOKUP;
        else
            act = ACT_UNKNOWN;

        pick = $urandom_range(0, KEY_POOL - 1);
        r    = $urandom_range(0, 99);
        if (r < 6)
            k = {$urandom, $urandom};
        else if (r < 14)
            k = key_pool[pick] ^ (64'd1 << $urandom_range(4, 63));
        else
            k = key_pool[pick];
        if ($urandom_range(0, 49) == 0)
            key_pool[pick] = {$urandom, $urandom};

        r = $urandom_range(0, 19);
        if (r == 0)
            v = '0;
        else if (r == 1)
            v = '1;
        else
            v = $urandom;
        send_item(act, k, v);
    endtask

    // Result side: own stall pattern, plus one long hold-off on request
    initial
    begin : receiver
        int mode;
        int mode_left;
        int tick;
        bit hold_done;

        mode      = 0;
        mode_left = 0;
        tick      = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                tick++;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 99) < 60);
                    2:       out_ready <= (tick % 4 != 0);
                    default: out_ready <= ($urandom_range(0, 99) < 20);
                endcase
                @(posedge clk);
            end
        end
    end

    // Hard stop for a hung run
    initial
    begin : watchdog
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("tb_hash_key_value_table: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int phase_limit[PHASES];
        int lim;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        action       = ACT_PUT;
        key          = '0;
        value        = '0;
        gaps_on      = 1'b1;
        burst_left   = 0;
        hold_off_req = 1'b0;
        phase_limit  = '{12, 127, 1, 64, 0, 0, 127};
        sb           = new();
        foreach (key_pool[i])
            key_pool[i] = {$urandom, $urandom};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, spare action, extreme keys and values
        send_item(ACT_LOOKUP, 64'd0, 32'd0);
        send_item(ACT_REMOVE, '1, 32'd0);
        send_item(ACT_UNKNOWN, 64'd0, '1);
        send_item(ACT_PUT, 64'd0, 32'd0);
        send_item(ACT_PUT, '1, '1);
        send_item(ACT_LOOKUP, 64'd0, 32'd0);
        send_item(ACT_LOOKUP, '1, 32'd0);
        send_item(ACT_PUT, 64'd0, '1);
        send_item(ACT_LOOKUP, 64'd0, 32'd0);

        // Fill one bucket, overflow it, free a way and reuse it
        send_item(ACT_PUT, 64'h05, 32'h1111_1111);
        send_item(ACT_PUT, 64'h15, 32'h2222_2222);
        send_item(ACT_PUT, 64'h25, 32'h3333_3333);
        send_item(ACT_PUT, 64'h35, 32'h4444_4444);
        send_item(ACT_PUT, 64'h45, 32'h5555_5555);
        send_item(ACT_REMOVE, 64'h15, 32'd0);
        send_item(ACT_PUT, 64'h45, 32'h5555_5555);
        send_item(ACT_LOOKUP, 64'h45, 32'd0);
        send_item(ACT_UNKNOWN, 64'h05, 32'hdead_beef);

        // Same bucket, different upper key bits
        send_item(ACT_LOOKUP, 64'h8000_0000_0000_0005, 32'd0);
        send_item(ACT_REMOVE, 64'h8000_0000_0000_0005, 32'd0);

        // Count at the limit: new keys refused, present keys still updated
        set_entry_limit(7'd6);
        send_item(ACT_PUT, 64'h77, 32'h0bad_cafe);
        send_item(ACT_PUT, 64'h05, 32'ha5a5_a5a5);

        // Zero limit refuses every new key
        set_entry_limit(7'd0);
        send_item(ACT_PUT, 64'h1234, 32'h1357_9bdf);
        send_item(ACT_LOOKUP, 64'h05, 32'd0);

        // Limit above capacity
        set_entry_limit(7'd127);
        send_item(ACT_PUT, 64'h1234, 32'h1357_9bdf);
        send_item(ACT_REMOVE, '1, 32'd0);

        // Random traffic over a sequence of limits
        for (int p = 0; p < PHASES; p++)
        begin
            lim = (p == 5) ? $urandom_range(2, 63) : phase_limit[p];
            set_entry_limit(lim[COUNT_BITS-1:0]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 40 == 0)
                    gaps_on = ($urandom_range(0, 2) != 0);
                // Back-to-back offers into a blocked output to fill the block
                if (p == 1 && i == 0)
                begin
                    gaps_on      = 1'b0;
                    hold_off_req = 1'b1;
                end
                if (i == PHASE_ITEMS / 2)
                    wait_drained();
                random_request();
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_hash_key_value_table: PASS");
        else
            $display("tb_hash_key_value_table: FAIL");
        $finish;
    end

endmodule

>>> files.f
sv/hkv_pkg.sv
sv/hkv_front.sv
sv/hkv_back.sv
sv/hash_key_value_table.sv
sv/hkv_checker.sv
dv/tb_hash_key_value_table.sv
